@@ hdl/fmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fmm_pkg;

   localparam int MAX_DIM_DEFAULT = 64;
   localparam int IDX_W           = 6;
   localparam int DIM_W           = 7;
   localparam int VALUE_W         = 32;
   localparam int REQ_DATA_W      = 48;
   localparam int REQ_USER_W      = 2;
   localparam int RSP_DATA_W      = 32;
   localparam int RSP_USER_W      = 1;
   localparam int CSR_INDEX_W     = 2;

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS_M       = 2'd0,
      CSR_COLS_N       = 2'd1,
      CSR_INNER_K      = 2'd2,
      CSR_B_TRANSPOSED = 2'd3
   } csr_index_type;

   // what the back end has to do with a queued item
   typedef enum logic [1:0] {
      JOB_LOAD_A = 2'd0,
      JOB_LOAD_B = 2'd1,
      JOB_QUERY  = 2'd2,
      JOB_QERR   = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type           kind;
      logic [IDX_W-1:0]       row;
      logic [IDX_W-1:0]       col;
      logic [VALUE_W-1:0]     value;
   } job_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows_m;
      logic [DIM_W-1:0] cols_n;
      logic [DIM_W-1:0] inner_k;
      logic             b_transposed;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_START,
      BK_WAIT,
      BK_OUT
   } back_state_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage
`default_nettype wire

@@ hdl/fmm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmm_front #(
   parameter int MAX_DIM = fmm_pkg::MAX_DIM_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [fmm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire  [fmm_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [fmm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [fmm_pkg::DIM_W-1:0]        csr_data,
   output fmm_pkg::cfg_type                 cfg,
   output logic                             push_valid,
   input  wire                              push_ready,
   output fmm_pkg::job_type                 push_job
);
   import fmm_pkg::*;

   logic [DIM_W-1:0] rows_m_ff, cols_n_ff, inner_k_ff;
   logic [DIM_W-1:0] rows_m_in, cols_n_in, inner_k_in;
   logic             b_trans_ff, b_trans_in;
   logic [DIM_W-1:0] dim_clamped;
   logic [IDX_W-1:0] row, col;
   logic [DIM_W-1:0] row_w, col_w;
   logic             keep;
   job_kind_type     kind;

   always_comb begin
      if (csr_data == '0) begin
         dim_clamped = DIM_W'(1);
      end else if (32'(csr_data) > 32'(MAX_DIM)) begin
         dim_clamped = DIM_W'(MAX_DIM);
      end else begin
         dim_clamped = csr_data;
      end
   end

   always_comb begin
      rows_m_in  = rows_m_ff;
      cols_n_in  = cols_n_ff;
      inner_k_in = inner_k_ff;
      b_trans_in = b_trans_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS_M:       rows_m_in  = dim_clamped;
            CSR_COLS_N:       cols_n_in  = dim_clamped;
            CSR_INNER_K:      inner_k_in = dim_clamped;
            CSR_B_TRANSPOSED: b_trans_in = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= DIM_W'(1);
         cols_n_ff  <= DIM_W'(1);
         inner_k_ff <= DIM_W'(1);
         b_trans_ff <= 1'b0;
      end else begin
         rows_m_ff  <= rows_m_in;
         cols_n_ff  <= cols_n_in;
         inner_k_ff <= inner_k_in;
         b_trans_ff <= b_trans_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = '{rows_m: rows_m_ff, cols_n: cols_n_ff, inner_k: inner_k_ff,
                        b_transposed: b_trans_ff};

   assign row   = req_tdata[IDX_W-1:0];
   assign col   = req_tdata[2*IDX_W-1:IDX_W];
   assign row_w = DIM_W'(row);
   assign col_w = DIM_W'(col);

   // sort the item and drop loads that fall outside the sizes and the unused code
   always_comb begin
      keep = 1'b0;
      kind = JOB_LOAD_A;
      unique case (req_kind_type'(req_tuser))
         REQ_LOAD_A: begin
            kind = JOB_LOAD_A;
            keep = (row_w < rows_m_ff) && (col_w < inner_k_ff);
         end
         REQ_LOAD_B: begin
            kind = JOB_LOAD_B;
            keep = b_trans_ff ? ((row_w < cols_n_ff) && (col_w < inner_k_ff))
                              : ((row_w < inner_k_ff) && (col_w < cols_n_ff));
         end
         REQ_QUERY: begin
            keep = 1'b1;
            kind = ((row_w < rows_m_ff) && (col_w < cols_n_ff)) ? JOB_QUERY : JOB_QERR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && keep;
   assign push_job   = '{kind: kind, row: row, col: col,
                         value: req_tdata[2*IDX_W+VALUE_W-1:2*IDX_W]};

endmodule
`default_nettype wire

@@ hdl/fmm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmm_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  fmm_pkg::job_type  push_job,
   output logic              pop_valid,
   input  wire               pop_ready,
   output fmm_pkg::job_type  pop_job
);
   import fmm_pkg::*;

   job_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ hdl/fmm_fmac.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmm_fmac (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] a_bits,
   input  wire  [31:0] b_bits,
   input  wire  [31:0] acc_bits,
   output logic        done,
   output logic [31:0] sum_bits
);
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam logic [2:0]  LAST_STAGE  = 3'd6;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else n = n + 6'd1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd0;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // m holds 24 significand bits, a guard bit and a sticky bit
   function automatic logic [31:0] fp_round(input logic sgn, input logic signed [10:0] e,
                                            input logic [25:0] m);
      logic [25:0]        sh;
      logic               lost;
      logic [10:0]        amt;
      logic [23:0]        man;
      logic               up;
      logic [24:0]        sum;
      logic signed [10:0] e2;
      logic [31:0]        r;
      if (e >= 11'sd1) begin
         man = m[25:2];
         up  = m[1] & (m[0] | m[2]);
         sum = {1'b0, man} + 25'(up);
         e2  = sum[24] ? e + 11'sd1 : e;
         if (e2 >= 11'sd255) r = {sgn, 8'hFF, 23'd0};
         else r = {sgn, e2[7:0], sum[22:0]};
      end else begin
         // result is subnormal before rounding
         amt = 11'd1 - e;
         if (amt >= 11'd26) begin
            sh   = 26'd0;
            lost = |m;
         end else begin
            sh   = m >> amt;
            lost = |(m & ((26'd1 << amt) - 26'd1));
         end
         man = sh[25:2];
         up  = sh[1] & (sh[0] | lost | sh[2]);
         sum = {1'b0, man} + 25'(up);
         r   = {sgn, 7'd0, sum[23:0]};
      end
      return r;
   endfunction

   logic               busy_ff;
   logic [2:0]         stage_ff;
   logic               done_ff;

   // multiply stages
   logic [47:0]        mp_ff;
   logic signed [10:0] me_ff;
   logic               msign_ff, mspec_ff;
   logic [31:0]        mspec_val_ff;
   logic signed [10:0] mne_ff;
   logic [25:0]        mnm_ff;
   logic [31:0]        p_ff;
   // add stages
   logic [26:0]        big_ff, small_ff;
   logic [7:0]         eb_ff;
   logic               asign_ff, asub_ff, aspec_ff;
   logic [31:0]        aspec_val_ff;
   logic [27:0]        s_ff;
   logic signed [10:0] ane_ff;
   logic [25:0]        anm_ff;
   logic               azero_ff;
   logic [31:0]        sum_ff;

   // multiply, first stage
   logic [7:0]         ea_f, eb_f;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0]        ma, mb;
   logic               m_spec_in;
   logic [31:0]        m_spec_val_in;
   logic               m_sign_in;

   always_comb begin
      ea_f   = a_bits[30:23];
      eb_f   = b_bits[30:23];
      a_nan  = (&ea_f) && (|a_bits[22:0]);
      b_nan  = (&eb_f) && (|b_bits[22:0]);
      a_inf  = (&ea_f) && !(|a_bits[22:0]);
      b_inf  = (&eb_f) && !(|b_bits[22:0]);
      a_zero = (ea_f == 8'd0) && !(|a_bits[22:0]);
      b_zero = (eb_f == 8'd0) && !(|b_bits[22:0]);
      ma     = {|ea_f, a_bits[22:0]};
      mb     = {|eb_f, b_bits[22:0]};
      m_sign_in     = a_bits[31] ^ b_bits[31];
      m_spec_in     = 1'b1;
      m_spec_val_in = {m_sign_in, 31'd0};
      if (a_nan) begin
         m_spec_val_in = a_bits | QUIET_BIT;
      end else if (b_nan) begin
         m_spec_val_in = b_bits | QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         m_spec_val_in = DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         m_spec_val_in = {m_sign_in, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         m_spec_val_in = {m_sign_in, 31'd0};
      end else begin
         m_spec_in = 1'b0;
      end
   end

   // multiply, normalize
   logic [5:0]  mlz;
   logic [47:0] mpn;
   always_comb begin
      mlz = lzc48(mp_ff);
      mpn = mp_ff << mlz;
   end

   // add, alignment
   logic [31:0] x, y, big, lesser;
   logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
   logic        a_spec_in;
   logic [31:0] a_spec_val_in;
   logic [7:0]  ebig, esmall, ediff;
   logic [26:0] big27, small27, small_sh;
   logic        small_lost;

   always_comb begin
      x      = acc_bits;
      y      = p_ff;
      x_nan  = (&x[30:23]) && (|x[22:0]);
      y_nan  = (&y[30:23]) && (|y[22:0]);
      x_inf  = (&x[30:23]) && !(|x[22:0]);
      y_inf  = (&y[30:23]) && !(|y[22:0]);
      x_zero = (x[30:0] == 31'd0);
      y_zero = (y[30:0] == 31'd0);
      a_spec_in     = 1'b1;
      a_spec_val_in = x;
      if (x_nan) begin
         a_spec_val_in = x | QUIET_BIT;
      end else if (y_nan) begin
         a_spec_val_in = y | QUIET_BIT;
      end else if (x_inf && y_inf && (x[31] != y[31])) begin
         a_spec_val_in = DEFAULT_NAN;
      end else if (x_inf) begin
         a_spec_val_in = x;
      end else if (y_inf) begin
         a_spec_val_in = y;
      end else if (x_zero && y_zero) begin
         a_spec_val_in = {x[31] & y[31], 31'd0};
      end else if (x_zero) begin
         a_spec_val_in = y;
      end else if (y_zero) begin
         a_spec_val_in = x;
      end else begin
         a_spec_in = 1'b0;
      end
      if (x[30:0] >= y[30:0]) begin
         big    = x;
         lesser = y;
      end else begin
         big    = y;
         lesser = x;
      end
      ebig    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      esmall  = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
      ediff   = ebig - esmall;
      big27   = {|big[30:23], big[22:0], 3'b000};
      small27 = {|lesser[30:23], lesser[22:0], 3'b000};
      if (ediff >= 8'd27) begin
         small_sh   = 27'd0;
         small_lost = |small27;
      end else begin
         small_sh   = small27 >> ediff;
         small_lost = |(small27 & ((27'd1 << ediff) - 27'd1));
      end
   end

   // add, normalize
   logic [4:0]  alz;
   logic [27:0] asn;
   always_comb begin
      alz = lzc28(s_ff);
      asn = s_ff << alz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         stage_ff <= 3'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            stage_ff <= 3'd1;
         end else if (busy_ff) begin
            if (stage_ff == LAST_STAGE) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               stage_ff <= stage_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mp_ff        <= ma * mb;
         me_ff        <= signed'(11'({3'd0, (ea_f == 8'd0) ? 8'd1 : ea_f}))
                         + signed'(11'({3'd0, (eb_f == 8'd0) ? 8'd1 : eb_f})) - 11'sd126;
         msign_ff     <= m_sign_in;
         mspec_ff     <= m_spec_in;
         mspec_val_ff <= m_spec_val_in;
      end
      if (busy_ff) begin
         unique case (stage_ff)
            3'd1: begin
               mne_ff <= me_ff - signed'(11'(mlz));
               mnm_ff <= {mpn[47:23], |mpn[22:0]};
            end
            3'd2: begin
               p_ff <= mspec_ff ? mspec_val_ff : fp_round(msign_ff, mne_ff, mnm_ff);
            end
            3'd3: begin
               big_ff       <= big27;
               small_ff     <= small_sh | 27'(small_lost);
               eb_ff        <= ebig;
               asign_ff     <= big[31];
               asub_ff      <= big[31] ^ lesser[31];
               aspec_ff     <= a_spec_in;
               aspec_val_ff <= a_spec_val_in;
            end
            3'd4: begin
               s_ff <= asub_ff ? ({1'b0, big_ff} - {1'b0, small_ff})
                               : ({1'b0, big_ff} + {1'b0, small_ff});
            end
            3'd5: begin
               azero_ff <= (s_ff == 28'd0);
               ane_ff   <= signed'(11'({3'd0, eb_ff})) + 11'sd1 - signed'(11'(alz));
               anm_ff   <= {asn[27:3], |asn[2:0]};
            end
            3'd6: begin
               if (aspec_ff) sum_ff <= aspec_val_ff;
               else if (azero_ff) sum_ff <= 32'd0;
               else sum_ff <= fp_round(asign_ff, ane_ff, anm_ff);
            end
            default: ;
         endcase
      end
   end

   assign done     = done_ff;
   assign sum_bits = sum_ff;

endmodule
`default_nettype wire

@@ hdl/fmm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmm_back #(
   parameter int MAX_DIM = fmm_pkg::MAX_DIM_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  fmm_pkg::cfg_type                 cfg,
   input  wire                              pop_valid,
   output logic                             pop_ready,
   input  fmm_pkg::job_type                 pop_job,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [fmm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [fmm_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import fmm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   function automatic logic [ADDR_W-1:0] slot(input logic [DIM_W-1:0] r,
                                              input logic [DIM_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
   endfunction

   logic [VALUE_W-1:0] a_mem [DEPTH];
   logic [VALUE_W-1:0] b_mem [DEPTH];
   logic [VALUE_W-1:0] a_rd_ff, b_rd_ff;

   back_state_type     state_ff, state_in;
   logic [DIM_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   qrow_ff, qrow_in, qcol_ff, qcol_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               out_free;
   logic               a_we, b_we, rd_en, mac_start, mac_done;
   logic [ADDR_W-1:0]  wr_addr, a_rd_addr, b_rd_addr;
   logic [VALUE_W-1:0] mac_sum;
   logic [DIM_W-1:0]   qrow_w, qcol_w;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign wr_addr  = slot(DIM_W'(pop_job.row), DIM_W'(pop_job.col));
   assign qrow_w   = DIM_W'(qrow_ff);
   assign qcol_w   = DIM_W'(qcol_ff);
   assign a_rd_addr = slot(qrow_w, k_ff);
   assign b_rd_addr = cfg.b_transposed ? slot(qcol_w, k_ff) : slot(k_ff, qcol_w);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      qrow_in       = qrow_ff;
      qcol_in       = qcol_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      pop_ready     = 1'b0;
      a_we          = 1'b0;
      b_we          = 1'b0;
      rd_en         = 1'b0;
      mac_start     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               unique case (pop_job.kind)
                  JOB_LOAD_A: begin
                     pop_ready = 1'b1;
                     a_we      = 1'b1;
                  end
                  JOB_LOAD_B: begin
                     pop_ready = 1'b1;
                     b_we      = 1'b1;
                  end
                  JOB_QERR: begin
                     if (out_free) begin
                        pop_ready     = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  JOB_QUERY: begin
                     pop_ready = 1'b1;
                     qrow_in   = pop_job.row;
                     qcol_in   = pop_job.col;
                     k_in      = '0;
                     acc_in    = '0;
                     state_in  = BK_READ;
                  end
                  default: ;
               endcase
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_START;
         end
         BK_START: begin
            mac_start = 1'b1;
            state_in  = BK_WAIT;
         end
         BK_WAIT: begin
            if (mac_done) begin
               acc_in = mac_sum;
               if (k_ff == cfg.inner_k - DIM_W'(1)) begin
                  state_in = BK_OUT;
               end else begin
                  k_in     = k_ff + DIM_W'(1);
                  state_in = BK_READ;
               end
            end
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_status_in = STATUS_OK;
               state_in      = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      qrow_ff       <= qrow_in;
      qcol_ff       <= qcol_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[wr_addr] <= pop_job.value;
      end
      if (rd_en) begin
         a_rd_ff <= a_mem[a_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[wr_addr] <= pop_job.value;
      end
      if (rd_en) begin
         b_rd_ff <= b_mem[b_rd_addr];
      end
   end

   fmm_fmac u_fmac (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_start),
      .a_bits   (a_rd_ff),
      .b_bits   (b_rd_ff),
      .acc_bits (acc_ff),
      .done     (mac_done),
      .sum_bits (mac_sum)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

@@ hdl/float_matrix_multiply_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Single-precision matrix engine: A and B are loaded one binary32 element per
// transfer into two on-chip memories, and a query returns one element of
// C = A x B, summed from +0.0 over k upward with round-to-nearest-even after
// every multiply and add. A query walks inner_k element pairs through one
// shared multiply-add unit, each pair in turn through memory read, 3 multiply
// stages, 4 add stages and hand-back; a query outside rows_m/cols_n answers
// with status 1 and no multiply-add. Loads outside the configured sizes are
// dropped and the unused request code is ignored. A two-deep queue sits
// between request decode and execution, and the result register lets the next
// request be taken while a result waits.
module float_matrix_multiply_engine #(
   parameter int MAX_DIM = fmm_pkg::MAX_DIM_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [fmm_pkg::REQ_DATA_W-1:0]   req_tdata,   // row_index, col_index, value
   input  wire  [fmm_pkg::REQ_USER_W-1:0]   req_tuser,   // req_type
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [fmm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // result_value
   output logic [fmm_pkg::RSP_USER_W-1:0]   rsp_tuser,   // status
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [fmm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [fmm_pkg::DIM_W-1:0]        csr_data
);
   import fmm_pkg::*;

   cfg_type cfg;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   fmm_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   fmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   fmm_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ hdl/fmm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fmm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire  [fmm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire  [fmm_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input wire                              csr_ready
);
   // no result may be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a range error always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("range error with nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port stalled");

   // a result cannot appear from nothing when a request is taken right after reset
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && req_tvalid && req_tready) |-> !rsp_tvalid)
      else $error("result before any request");

endmodule

bind float_matrix_multiply_engine fmm_checker u_fmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
`default_nettype wire
